// File: design/enfir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enfir_pkg: shared types and constants of the edge normalized FIR
// Field widths, accumulator and divider widths, opcodes and register map.
// ----------------------------------------------------------------------------
package enfir_pkg;

  // default number of kernel taps
  localparam int TAPS_DEF = 16;

  // item field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int VAL_W  = 16;
  localparam int POS_W  = 4;

  // sample counter saturates at 31, kernel length register is 5 bits
  localparam int CNT_W  = 5;
  localparam int KLEN_W = 5;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 5'd31;
  localparam logic [KLEN_W-1:0] KLEN_RST = 5'd16;

  // digit-serial multiply: one 4-bit sample digit per cycle
  localparam int DIG_W   = 4;
  localparam int DIGITS  = VAL_W / DIG_W;
  localparam int DCNT_W  = $clog2(DIGITS);

  // accumulator and tap sum widths (at most 31 terms)
  localparam int ACC_W  = 40;
  localparam int MAG_W  = 24;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_KLEN = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_DATA  = 2'd1,
    OP_START = 2'd2
  } op_e;

endpackage

// File: design/enfir_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enfir_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds while re_i low.
// ----------------------------------------------------------------------------
module enfir_ram #(
  parameter int DATA_W = enfir_pkg::VAL_W,
  parameter int DEPTH  = enfir_pkg::TAPS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/enfir_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// enfir_div: bit-serial restoring divider for unsigned magnitudes
// One quotient bit per cycle; done_o pulses once the last quotient bit has shifted in.
// ----------------------------------------------------------------------------
module enfir_div #(
  parameter int DVD_W = enfir_pkg::ACC_W,
  parameter int DVS_W = enfir_pkg::MAG_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W:0]   rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   sh;
  logic [DVS_W+1:0] diff;
  logic             borrow;

  // shift the next dividend bit into the partial remainder and trial-subtract
  assign sh     = {rem_q[DVS_W-1:0], dvd_q[DVD_W-1]};
  assign diff   = {1'b0, sh} - {2'b00, dvs_q};
  assign borrow = diff[DVS_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in behind the dividend bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ~borrow};
      rem_q <= borrow ? sh : diff[DVS_W:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// File: design/edge_normalized_fir_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_normalized_fir_unit: left-border FIR with partial-kernel normalization
// Load, start and out-of-border sample items complete in the idle state.
// A border sample n runs a digit-serial multiply-accumulate over taps 0..n
// (one tap fetch plus four 4-bit digits per tap), one tap-sum check, the
// divider and one result load, after which the next item goes in; a zero tap
// sum skips the divider, and a stalled result holds the next item back.
// Reset clears taps to zero through valid bits, the sample count, and sets
// kernel_length to 16; the result register may still hold while the next item runs.
// ----------------------------------------------------------------------------
module edge_normalized_fir_unit #(
  parameter int TAPS = enfir_pkg::TAPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [enfir_pkg::OP_W-1:0]          opcode_i,
  input  logic [enfir_pkg::IDX_W-1:0]         tap_index_i,
  input  logic signed [enfir_pkg::VAL_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [enfir_pkg::VAL_W-1:0]  result_value_o,
  output logic [enfir_pkg::POS_W-1:0]         sample_position_o,
  output logic                                div_by_zero_o,
  output logic                                saturated_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [enfir_pkg::PADDR_W-1:0]       paddr,
  input  logic [enfir_pkg::PDATA_W-1:0]       pwdata,
  output logic [enfir_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  import enfir_pkg::*;

  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [ACC_W-1:0] POS_LIM = ACC_W'(2 ** (VAL_W - 1) - 1);
  localparam logic [ACC_W-1:0] NEG_LIM = ACC_W'(2 ** (VAL_W - 1));

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_MUL   = 6'b000100,
    S_NORM  = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [KLEN_W-1:0]       klen_q;
  logic [CNT_W-1:0]        n_q, n_d;
  logic [CNT_W-1:0]        j_q, j_d;
  logic [DCNT_W-1:0]       dig_q, dig_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [MAG_W-1:0] mag_q, mag_d;
  logic                    sign_q, sign_d;
  logic                    dz_q, dz_d;
  logic [TAPS-1:0]         tap_vld_q;
  logic                    vld_bit_q;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] res_q;
  logic [POS_W-1:0]        pos_q;
  logic                    dzo_q;
  logic                    sat_q;

  logic                    tap_we;
  logic                    hist_we;
  logic                    rd_en;
  logic                    div_start;
  logic                    div_done;
  logic                    out_load;
  logic                    cfg_we;

  logic signed [VAL_W-1:0] tap_rdata;
  logic signed [VAL_W-1:0] hist_rdata;
  logic signed [VAL_W-1:0] tap_val;
  logic [DIG_W-1:0]        dsel;
  logic signed [DIG_W:0]   digit;
  logic signed [VAL_W+DIG_W:0] pp;
  logic signed [ACC_W-1:0] pp_ext;
  logic [ACC_W-1:0]        acc_abs;
  logic [MAG_W-1:0]        mag_abs;
  logic [ACC_W-1:0]        qmag;
  logic signed [VAL_W-1:0] res_d;
  logic                    sat_d;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_KLEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_RST;
    end else if (cfg_we) begin
      klen_q <= pwdata[KLEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_KLEN) begin
      prdata = PDATA_W'(klen_q);
    end
  end

  // --------------------------------------------------------------------------
  // tap and sample stores
  // --------------------------------------------------------------------------
  enfir_ram #(
    .DATA_W (VAL_W),
    .DEPTH  (TAPS)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we),
    .waddr_i (AW'(tap_index_i)),
    .wdata_i (value_i),
    .re_i    (rd_en),
    .raddr_i (AW'(j_q)),
    .rdata_o (tap_rdata)
  );

  enfir_ram #(
    .DATA_W (VAL_W),
    .DEPTH  (TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (AW'(cnt_q)),
    .wdata_i (value_i),
    .re_i    (rd_en),
    .raddr_i (AW'(n_q - j_q)),
    .rdata_o (hist_rdata)
  );

  // a tap never loaded since reset reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_vld_q <= '0;
    end else if (tap_we) begin
      tap_vld_q[AW'(tap_index_i)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      vld_bit_q <= tap_vld_q[AW'(j_q)];
    end
  end

  // --------------------------------------------------------------------------
  // digit-serial partial product: tap times one 4-bit sample digit
  // --------------------------------------------------------------------------
  assign tap_val = vld_bit_q ? tap_rdata : '0;
  assign dsel    = hist_rdata[DIG_W * int'(dig_q) +: DIG_W];
  // top digit carries the sample's sign
  assign digit   = (dig_q == DCNT_W'(DIGITS - 1)) ? $signed({dsel[DIG_W-1], dsel})
                                                  : $signed({1'b0, dsel});
  assign pp      = tap_val * digit;
  assign pp_ext  = ACC_W'(pp);

  assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign mag_abs = mag_q[MAG_W-1] ? MAG_W'(-mag_q) : MAG_W'(mag_q);

  enfir_div #(
    .DVD_W (ACC_W),
    .DVS_W (MAG_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_abs),
    .divisor_i  (mag_abs),
    .done_o     (div_done),
    .quotient_o (qmag)
  );

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    j_d       = j_q;
    dig_d     = dig_q;
    acc_d     = acc_q;
    mag_d     = mag_q;
    sign_d    = sign_q;
    dz_d      = dz_q;
    tap_we    = 1'b0;
    hist_we   = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_LOAD: begin
              tap_we = (int'(tap_index_i) < TAPS);
            end
            OP_START: begin
              cnt_d = '0;
            end
            OP_DATA: begin
              hist_we = (int'(cnt_q) < TAPS);
              if (cnt_q < CNT_MAX) begin
                cnt_d = cnt_q + 1'b1;
              end
              // only samples inside the border give a result
              if ((cnt_q < klen_q) && (int'(cnt_q) < TAPS)) begin
                n_d     = cnt_q;
                j_d     = '0;
                acc_d   = '0;
                mag_d   = '0;
                state_d = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        rd_en   = 1'b1;
        dig_d   = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        acc_d = acc_q + (pp_ext <<< (DIG_W * int'(dig_q)));
        if (dig_q == '0) begin
          mag_d = mag_q + MAG_W'(tap_val);
        end
        dig_d = dig_q + 1'b1;
        if (dig_q == DCNT_W'(DIGITS - 1)) begin
          if (j_q == n_q) begin
            state_d = S_NORM;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_FETCH;
          end
        end
      end
      S_NORM: begin
        sign_d = acc_q[ACC_W-1] ^ mag_q[MAG_W-1];
        if (mag_q == '0) begin
          dz_d    = 1'b1;
          state_d = S_OUT;
        end else begin
          dz_d      = 1'b0;
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free or drains this cycle
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    j_q    <= j_d;
    dig_q  <= dig_d;
    acc_q  <= acc_d;
    mag_q  <= mag_d;
    sign_q <= sign_d;
    dz_q   <= dz_d;
  end

  // --------------------------------------------------------------------------
  // sign restore and saturation
  // --------------------------------------------------------------------------
  always_comb begin
    res_d = '0;
    sat_d = 1'b0;
    if (dz_q) begin
      res_d = '0;
    end else if (sign_q) begin
      if (qmag > NEG_LIM) begin
        res_d = $signed(NEG_LIM[VAL_W-1:0]);
        sat_d = 1'b1;
      end else begin
        res_d = $signed(VAL_W'(-qmag));
      end
    end else begin
      if (qmag > POS_LIM) begin
        res_d = $signed(POS_LIM[VAL_W-1:0]);
        sat_d = 1'b1;
      end else begin
        res_d = $signed(qmag[VAL_W-1:0]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
      pos_q <= POS_W'(n_q);
      dzo_q <= dz_q;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_value_o    = res_q;
  assign sample_position_o = pos_q;
  assign div_by_zero_o     = dzo_q;
  assign saturated_o       = sat_q;

endmodule
